// ===== rtl/mrga_pkg.sv =====
// Package for the message router and GPIO agent.
// Holds the transaction structs, configuration struct and command codes.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package mrga_pkg;

  localparam logic [7:0] DEFAULT_ADDR = 8'h0A;
  localparam logic [7:0] SERIAL_ADDR  = 8'hFF;
  localparam logic [7:0] FLAG_ACK     = 8'h80;
  localparam logic [7:0] FLAG_UART    = 8'h40;
  localparam logic [7:0] MASK_RESET   = 8'hFF;

  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_GET_PORT = 8'h01;
  localparam logic [7:0] OP_SET_PORT = 8'h02;
  localparam logic [7:0] OP_GET_DIR  = 8'h03;
  localparam logic [7:0] OP_SET_DIR  = 8'h04;
  localparam logic [7:0] OP_GET_ADDR = 8'h05;
  localparam logic [7:0] OP_SET_ADDR = 8'h06;
  localparam logic [7:0] OP_FWD      = 8'h3F;

  localparam logic [5:0] LEN_PORT  = 6'd9;
  localparam logic [5:0] LEN_ADDR  = 6'd6;
  localparam logic [5:0] LEN_OTHER = 6'd5;

  // Register indexes on the configuration port (taken from paddr bit 2).
  localparam logic REG_PORT0_MASK = 1'b0;
  localparam logic REG_PORT1_MASK = 1'b1;

  localparam int ADDR_W = 3;

  typedef struct packed {
    logic       from_radio;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] sta;
    logic [7:0] seq;
    logic [7:0] cmd;
    logic [7:0] arg1;
    logic [7:0] arg2;
    logic [7:0] arg3;
    logic [7:0] arg4;
    logic [5:0] msg_len;
  } msg_in_t;

  typedef struct packed {
    logic       to_radio;
    logic [5:0] pipe;
    logic [7:0] out_src;
    logic [7:0] out_dst;
    logic [7:0] out_sta;
    logic [7:0] out_seq;
    logic [7:0] out_b0;
    logic [7:0] out_b1;
    logic [7:0] out_b2;
    logic [7:0] out_b3;
    logic [7:0] out_b4;
    logic [5:0] out_len;
  } msg_out_t;

  typedef struct packed {
    logic [7:0] port0_valid_mask;
    logic [7:0] port1_valid_mask;
  } cfg_t;

  function automatic logic [7:0] masked_write(input logic [7:0] cur, input logic [7:0] val,
                                              input logic [7:0] sel, input logic [7:0] valid);
    logic [7:0] m;
    m = sel & valid;
    return (cur & ~m) | (val & m);
  endfunction

endpackage

// ===== rtl/message_router_gpio_agent.sv =====
// Top level of the message router and GPIO agent.
// Input register, result register and handshake; instantiates mrga_regs
// and mrga_exec, and uses mrga_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------
//   in       | in_valid / in_ready    | in_data  (mrga_pkg::msg_in_t)
//   out      | out_valid / out_ready  | out_data (mrga_pkg::msg_out_t)
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// A message is latched in the input register, decided and executed from there,
// and its result lands in the result register; one message is taken per
// cycle while no stalled reply holds the result register.
// A dropped acknowledgement leaves the input register without using the
// result register. While a result waits, the input register still takes one
// more message. Synchronous reset restores the node address to 0x0A and
// clears the port and direction registers.
module message_router_gpio_agent (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mrga_pkg::msg_in_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mrga_pkg::msg_out_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrga_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  mrga_pkg::cfg_t     cfg;
  mrga_pkg::msg_in_t  in_q;
  mrga_pkg::msg_out_t res;
  logic               in_v;
  logic               drop;
  logic               fire;
  logic               load;
  logic               in_acc;

  mrga_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mrga_exec u_exec (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .msg  (in_q),
    .cfg  (cfg),
    .res  (res),
    .drop (drop)
  );

  assign fire     = in_v && (drop || !out_valid || out_ready);
  assign load     = fire && !drop;
  assign in_ready = !in_v || fire;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_acc) begin
      in_v <= 1'b1;
    end else if (fire) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("executed transaction did not reach the result register");

  a_drop_keeps_result: assert property (@(posedge clk) disable iff (rst)
    fire && drop && out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("dropped acknowledgement disturbed a waiting result");

  a_held_input: assert property (@(posedge clk) disable iff (rst)
    in_v && !fire |=> in_v && $stable(in_q))
    else $error("stalled input transaction was lost or changed");

endmodule

// ===== rtl/mrga_regs.sv =====
// Configuration registers of the message router behind an APB-style port.
// Holds the two port valid masks; depends on mrga_pkg.
module mrga_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrga_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output mrga_pkg::cfg_t              cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.port0_valid_mask <= mrga_pkg::MASK_RESET;
      cfg.port1_valid_mask <= mrga_pkg::MASK_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        mrga_pkg::REG_PORT0_MASK: cfg.port0_valid_mask <= pwdata[7:0];
        mrga_pkg::REG_PORT1_MASK: cfg.port1_valid_mask <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mrga_pkg::REG_PORT0_MASK: prdata = {24'd0, cfg.port0_valid_mask};
      mrga_pkg::REG_PORT1_MASK: prdata = {24'd0, cfg.port1_valid_mask};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/mrga_exec.sv =====
// Routing decision and command execution for one registered message.
// Holds the node address and the port output and direction registers;
// depends on mrga_pkg.
module mrga_exec (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  mrga_pkg::msg_in_t  msg,
  input  mrga_pkg::cfg_t     cfg,
  output mrga_pkg::msg_out_t res,
  output logic               drop
);

  logic [7:0] node_addr, node_addr_next;
  logic [7:0] port0_out, port0_out_next;
  logic [7:0] port1_out, port1_out_next;
  logic [7:0] port0_dir, port0_dir_next;
  logic [7:0] port1_dir, port1_dir_next;

  logic for_node;
  logic ack;
  logic is_cmd;

  assign for_node = (msg.dst == node_addr) ||
                    (msg.dst == mrga_pkg::SERIAL_ADDR && msg.src == mrga_pkg::SERIAL_ADDR);
  assign ack      = msg.sta[7];
  assign is_cmd   = for_node && !ack && (msg.cmd != mrga_pkg::OP_FWD);
  assign drop     = for_node && ack && !msg.sta[6];

  // Register updates of the command; the reply reports the updated values.
  always_comb begin
    node_addr_next = node_addr;
    port0_out_next = port0_out;
    port1_out_next = port1_out;
    port0_dir_next = port0_dir;
    port1_dir_next = port1_dir;
    if (is_cmd) begin
      case (msg.cmd)
        mrga_pkg::OP_SET_PORT: begin
          port0_out_next = mrga_pkg::masked_write(port0_out, msg.arg1, msg.arg2,
                                                  cfg.port0_valid_mask);
          port1_out_next = mrga_pkg::masked_write(port1_out, msg.arg3, msg.arg4,
                                                  cfg.port1_valid_mask);
        end
        mrga_pkg::OP_SET_DIR: begin
          port0_dir_next = mrga_pkg::masked_write(port0_dir, msg.arg1, msg.arg2,
                                                  cfg.port0_valid_mask);
          port1_dir_next = mrga_pkg::masked_write(port1_dir, msg.arg3, msg.arg4,
                                                  cfg.port1_valid_mask);
        end
        mrga_pkg::OP_SET_ADDR: node_addr_next = msg.arg1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_addr <= mrga_pkg::DEFAULT_ADDR;
      port0_out <= 8'd0;
      port1_out <= 8'd0;
      port0_dir <= 8'd0;
      port1_dir <= 8'd0;
    end else if (fire) begin
      node_addr <= node_addr_next;
      port0_out <= port0_out_next;
      port1_out <= port1_out_next;
      port0_dir <= port0_dir_next;
      port1_dir <= port1_dir_next;
    end
  end

  always_comb begin
    res.pipe    = msg.sta[5:0];
    res.out_seq = msg.seq;
    res.out_b0  = msg.cmd;
    if (!for_node) begin
      res.to_radio = 1'b1;
      res.out_src  = msg.from_radio ? msg.src : node_addr;
      res.out_dst  = msg.dst;
      res.out_sta  = msg.from_radio ? msg.sta : (msg.sta | mrga_pkg::FLAG_UART);
      res.out_b1   = msg.arg1;
      res.out_b2   = msg.arg2;
      res.out_b3   = msg.arg3;
      res.out_b4   = msg.arg4;
      res.out_len  = msg.msg_len;
    end else if (!is_cmd) begin
      // Acknowledgement with the UART flag, or the forward command: pass to UART.
      res.to_radio = 1'b0;
      res.out_src  = msg.src;
      res.out_dst  = msg.dst;
      res.out_sta  = msg.sta;
      res.out_b1   = msg.arg1;
      res.out_b2   = msg.arg2;
      res.out_b3   = msg.arg3;
      res.out_b4   = msg.arg4;
      res.out_len  = msg.msg_len;
    end else begin
      res.to_radio = msg.from_radio;
      res.out_src  = node_addr_next;
      res.out_dst  = msg.src;
      res.out_sta  = msg.sta | mrga_pkg::FLAG_ACK;
      res.out_b1   = 8'd0;
      res.out_b2   = 8'd0;
      res.out_b3   = 8'd0;
      res.out_b4   = 8'd0;
      case (msg.cmd)
        mrga_pkg::OP_NOP: res.out_len = msg.msg_len;
        mrga_pkg::OP_GET_PORT, mrga_pkg::OP_SET_PORT: begin
          res.out_b1  = port0_out_next & msg.arg2;
          res.out_b2  = cfg.port0_valid_mask & msg.arg2;
          res.out_b3  = port1_out_next & msg.arg4;
          res.out_b4  = cfg.port1_valid_mask & msg.arg4;
          res.out_len = mrga_pkg::LEN_PORT;
        end
        mrga_pkg::OP_GET_DIR, mrga_pkg::OP_SET_DIR: begin
          res.out_b1  = port0_dir_next & msg.arg2;
          res.out_b2  = cfg.port0_valid_mask & msg.arg2;
          res.out_b3  = port1_dir_next & msg.arg4;
          res.out_b4  = cfg.port1_valid_mask & msg.arg4;
          res.out_len = mrga_pkg::LEN_PORT;
        end
        mrga_pkg::OP_GET_ADDR, mrga_pkg::OP_SET_ADDR: begin
          res.out_b1  = node_addr_next;
          res.out_len = mrga_pkg::LEN_ADDR;
        end
        default: res.out_len = mrga_pkg::LEN_OTHER;
      endcase
    end
  end

endmodule

// ===== verif/mrga_reply_checker.sv =====
`timescale 1ns / 100ps
// Reply checker for the message router and GPIO agent: watches the message,
// reply and configuration channels, predicts each reply and compares it.
// Depends on mrga_pkg for the transaction types, flags and command codes.
module mrga_reply_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  mrga_pkg::msg_in_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  mrga_pkg::msg_out_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [mrga_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          fail_count,
  output int                          pending
);

  // Predicted node state and the configuration copy.
  logic [7:0] my_addr;
  logic [7:0] p0_out;
  logic [7:0] p1_out;
  logic [7:0] p0_dir;
  logic [7:0] p1_dir;
  logic [7:0] keep0;
  logic [7:0] keep1;

  mrga_pkg::msg_out_t replies_due[$];
  int mismatches = 0;

  function automatic logic [7:0] merge_bits(input logic [7:0] cur, input logic [7:0] val,
                                            input logic [7:0] sel, input logic [7:0] keep);
    logic [7:0] hit;
    hit = sel & keep;
    return (val & hit) | (cur & ~hit);
  endfunction

  // Works out the reply to one message and applies any command side effect.
  // Returns 0 when the message is swallowed.
  function automatic bit route_message(input mrga_pkg::msg_in_t m,
                                       output mrga_pkg::msg_out_t r);
    logic for_us;
    r = '0;
    r.pipe = m.sta[5:0];
    for_us = (m.dst == my_addr) ||
             (m.dst == mrga_pkg::SERIAL_ADDR && m.src == mrga_pkg::SERIAL_ADDR);
    if (!for_us) begin
      r.to_radio = 1'b1;
      r.out_src = m.from_radio ? m.src : my_addr;
      r.out_dst = m.dst;
      r.out_sta = m.from_radio ? m.sta : (m.sta | mrga_pkg::FLAG_UART);
      r.out_seq = m.seq;
      r.out_b0 = m.cmd;
      r.out_b1 = m.arg1;
      r.out_b2 = m.arg2;
      r.out_b3 = m.arg3;
      r.out_b4 = m.arg4;
      r.out_len = m.msg_len;
      return 1'b1;
    end
    if ((m.sta & mrga_pkg::FLAG_ACK) != 0 || m.cmd == mrga_pkg::OP_FWD) begin
      // An acknowledgement only travels on when it carries the UART flag.
      if ((m.sta & mrga_pkg::FLAG_ACK) != 0 && (m.sta & mrga_pkg::FLAG_UART) == 0)
        return 1'b0;
      r.to_radio = 1'b0;
      r.out_src = m.src;
      r.out_dst = m.dst;
      r.out_sta = m.sta;
      r.out_seq = m.seq;
      r.out_b0 = m.cmd;
      r.out_b1 = m.arg1;
      r.out_b2 = m.arg2;
      r.out_b3 = m.arg3;
      r.out_b4 = m.arg4;
      r.out_len = m.msg_len;
      return 1'b1;
    end
    case (m.cmd)
      mrga_pkg::OP_NOP: begin
        r.out_len = m.msg_len;
      end
      mrga_pkg::OP_SET_PORT, mrga_pkg::OP_GET_PORT: begin
        if (m.cmd == mrga_pkg::OP_SET_PORT) begin
          p0_out = merge_bits(p0_out, m.arg1, m.arg2, keep0);
          p1_out = merge_bits(p1_out, m.arg3, m.arg4, keep1);
        end
        r.out_b1 = p0_out & m.arg2;
        r.out_b2 = keep0 & m.arg2;
        r.out_b3 = p1_out & m.arg4;
        r.out_b4 = keep1 & m.arg4;
        r.out_len = mrga_pkg::LEN_PORT;
      end
      mrga_pkg::OP_SET_DIR, mrga_pkg::OP_GET_DIR: begin
        if (m.cmd == mrga_pkg::OP_SET_DIR) begin
          p0_dir = merge_bits(p0_dir, m.arg1, m.arg2, keep0);
          p1_dir = merge_bits(p1_dir, m.arg3, m.arg4, keep1);
        end
        r.out_b1 = p0_dir & m.arg2;
        r.out_b2 = keep0 & m.arg2;
        r.out_b3 = p1_dir & m.arg4;
        r.out_b4 = keep1 & m.arg4;
        r.out_len = mrga_pkg::LEN_PORT;
      end
      mrga_pkg::OP_SET_ADDR, mrga_pkg::OP_GET_ADDR: begin
        if (m.cmd == mrga_pkg::OP_SET_ADDR)
          my_addr = m.arg1;
        r.out_b1 = my_addr;
        r.out_len = mrga_pkg::LEN_ADDR;
      end
      default: begin
        r.out_len = mrga_pkg::LEN_OTHER;
      end
    endcase
    r.to_radio = m.from_radio;
    r.out_src = my_addr;
    r.out_dst = m.src;
    r.out_sta = m.sta | mrga_pkg::FLAG_ACK;
    r.out_seq = m.seq;
    r.out_b0 = m.cmd;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("reply field %s: expected 0x%02h, got 0x%02h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    mrga_pkg::msg_out_t want;
    mrga_pkg::msg_out_t got;
    if (rst) begin
      my_addr = mrga_pkg::DEFAULT_ADDR;
      p0_out = '0;
      p1_out = '0;
      p0_dir = '0;
      p1_dir = '0;
      keep0 = mrga_pkg::MASK_RESET;
      keep1 = mrga_pkg::MASK_RESET;
      replies_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if ((paddr >> 2) == mrga_pkg::REG_PORT0_MASK)
          keep0 = pwdata[7:0];
        else if ((paddr >> 2) == mrga_pkg::REG_PORT1_MASK)
          keep1 = pwdata[7:0];
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (replies_due.size() == 0) begin
          $error("reply transaction with no reply expected: %h", got);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          check_field("to_radio", 8'(want.to_radio), 8'(got.to_radio));
          check_field("pipe", 8'(want.pipe), 8'(got.pipe));
          check_field("out_src", want.out_src, got.out_src);
          check_field("out_dst", want.out_dst, got.out_dst);
          check_field("out_sta", want.out_sta, got.out_sta);
          check_field("out_seq", want.out_seq, got.out_seq);
          check_field("out_b0", want.out_b0, got.out_b0);
          check_field("out_b1", want.out_b1, got.out_b1);
          check_field("out_b2", want.out_b2, got.out_b2);
          check_field("out_b3", want.out_b3, got.out_b3);
          check_field("out_b4", want.out_b4, got.out_b4);
          check_field("out_len", 8'(want.out_len), 8'(got.out_len));
        end
      end
      if (in_valid && in_ready) begin
        if (route_message(in_data, want))
          replies_due.push_back(want);
      end
    end
    pending <= replies_due.size();
    fail_count <= mismatches;
  end

endmodule

// ===== verif/message_router_gpio_agent_test.sv =====
`timescale 1ns / 100ps
// Top of the message router and GPIO agent testbench: clock, reset, message
// and reply traffic, mask register writes and the final verdict.
// Depends on mrga_pkg, message_router_gpio_agent and mrga_reply_checker.
module message_router_gpio_agent_test;

  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_PHASES = 6;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  mrga_pkg::msg_in_t           in_data;
  logic                        out_valid;
  logic                        out_ready;
  mrga_pkg::msg_out_t          out_data;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [mrga_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  int                          fail_count;
  int                          pending;

  // Node address as the stimulus expects it, so that most commands hit.
  logic [7:0] node_guess = mrga_pkg::DEFAULT_ADDR;
  bit         no_gaps = 1'b0;
  bit         squeeze_req = 1'b0;
  int         cycles = 0;

  int unsigned phase_items[NUM_PHASES] = '{300, 200, 300, 350, 250, 250};
  logic [7:0]  phase_keep0[NUM_PHASES] = '{8'hA5, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
  logic [7:0]  phase_keep1[NUM_PHASES] = '{8'h3C, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};

  message_router_gpio_agent i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mrga_reply_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    if (no_gaps)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic mrga_pkg::msg_in_t make_msg(input logic radio, input logic [7:0] src,
                                                 input logic [7:0] dst, input logic [7:0] sta,
                                                 input logic [7:0] seq, input logic [7:0] cmd,
                                                 input logic [7:0] a1, input logic [7:0] a2,
                                                 input logic [7:0] a3, input logic [7:0] a4,
                                                 input logic [5:0] len);
    mrga_pkg::msg_in_t m;
    m.from_radio = radio;
    m.src = src;
    m.dst = dst;
    m.sta = sta;
    m.seq = seq;
    m.cmd = cmd;
    m.arg1 = a1;
    m.arg2 = a2;
    m.arg3 = a3;
    m.arg4 = a4;
    m.msg_len = len;
    return m;
  endfunction

  // Mostly well-formed commands for this node, with forwarded traffic and
  // acknowledgements mixed in.
  function automatic mrga_pkg::msg_in_t random_msg();
    mrga_pkg::msg_in_t m;
    int roll;
    m = make_msg(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom), 6'($urandom_range(5, 32)));
    if ($urandom_range(0, 9) == 0)
      m.msg_len = 6'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      return m;
    end else if (roll < 22) begin
      m.dst = node_guess;
      m.sta = m.sta | mrga_pkg::FLAG_ACK;
    end else begin
      if (roll < 28) begin
        m.dst = mrga_pkg::SERIAL_ADDR;
        m.src = mrga_pkg::SERIAL_ADDR;
      end else begin
        m.dst = node_guess;
      end
      m.sta = m.sta & ~mrga_pkg::FLAG_ACK;
      case ($urandom_range(0, 9))
        0: m.cmd = mrga_pkg::OP_NOP;
        1: m.cmd = mrga_pkg::OP_GET_PORT;
        2: m.cmd = mrga_pkg::OP_SET_PORT;
        3: m.cmd = mrga_pkg::OP_GET_DIR;
        4: m.cmd = mrga_pkg::OP_SET_DIR;
        5: m.cmd = mrga_pkg::OP_GET_ADDR;
        6: m.cmd = ($urandom_range(0, 3) == 0) ? mrga_pkg::OP_SET_ADDR : mrga_pkg::OP_GET_ADDR;
        7: m.cmd = mrga_pkg::OP_FWD;
        8: m.cmd = 8'($urandom);
        default: m.cmd = mrga_pkg::OP_SET_PORT;
      endcase
    end
    return m;
  endfunction

  task automatic send_msg(input mrga_pkg::msg_in_t m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (((m.dst == node_guess) ||
         (m.dst == mrga_pkg::SERIAL_ADDR && m.src == mrga_pkg::SERIAL_ADDR)) &&
        (m.sta & mrga_pkg::FLAG_ACK) == 0 && m.cmd == mrga_pkg::OP_SET_ADDR)
      node_guess = m.arg1;
  endtask

  // Waits until every reply has come back and any dropped message has left.
  // The first edge lets the reply count take in the last accepted message.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mask(input logic reg_idx, input logic [7:0] value);
    logic [31:0] filler;
    filler = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {filler[31:8], value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed();
    logic [7:0] both;
    both = mrga_pkg::FLAG_ACK | mrga_pkg::FLAG_UART;
    send_msg(make_msg(1'b0, 8'h11, mrga_pkg::DEFAULT_ADDR, 8'h00, 8'h00, mrga_pkg::OP_GET_ADDR,
                      8'h00, 8'h00, 8'h00, 8'h00, 6'd5));
    send_msg(make_msg(1'b1, 8'h22, mrga_pkg::DEFAULT_ADDR, 8'h3F, 8'hFF, mrga_pkg::OP_NOP,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd32));
    // Lengths outside the legal range are copied into a nop reply.
    send_msg(make_msg(1'b0, 8'h00, mrga_pkg::DEFAULT_ADDR, 8'h01, 8'h02, mrga_pkg::OP_NOP,
                      8'h12, 8'h34, 8'h56, 8'h78, 6'd0));
    send_msg(make_msg(1'b1, 8'hFE, mrga_pkg::DEFAULT_ADDR, 8'h20, 8'h03, mrga_pkg::OP_NOP,
                      8'h00, 8'h00, 8'h00, 8'h00, 6'd63));
    send_msg(make_msg(1'b0, 8'h31, mrga_pkg::DEFAULT_ADDR, 8'h05, 8'h04, mrga_pkg::OP_SET_PORT,
                      8'hFF, 8'hFF, 8'hA5, 8'hFF, 6'd9));
    send_msg(make_msg(1'b1, 8'h31, mrga_pkg::DEFAULT_ADDR, 8'h05, 8'h05, mrga_pkg::OP_GET_PORT,
                      8'h00, 8'h0F, 8'h00, 8'hF0, 6'd9));
    send_msg(make_msg(1'b0, 8'h44, mrga_pkg::DEFAULT_ADDR, 8'h3F, 8'h06, mrga_pkg::OP_SET_DIR,
                      8'h5A, 8'hFF, 8'hC3, 8'h0F, 6'd9));
    send_msg(make_msg(1'b1, 8'h44, mrga_pkg::DEFAULT_ADDR, 8'h00, 8'h07, mrga_pkg::OP_GET_DIR,
                      8'h00, 8'hFF, 8'h00, 8'hFF, 6'd9));
    send_msg(make_msg(1'b0, 8'h55, mrga_pkg::DEFAULT_ADDR, 8'h10, 8'h08, 8'h07,
                      8'hAA, 8'hBB, 8'hCC, 8'hDD, 6'd20));
    send_msg(make_msg(1'b1, 8'h55, mrga_pkg::DEFAULT_ADDR, 8'h10, 8'h09, 8'hFF,
                      8'hAA, 8'hBB, 8'hCC, 8'hDD, 6'd20));
    send_msg(make_msg(1'b1, 8'h66, mrga_pkg::DEFAULT_ADDR, 8'h2A, 8'h0A, mrga_pkg::OP_FWD,
                      8'h01, 8'h02, 8'h03, 8'h04, 6'd17));
    send_msg(make_msg(1'b0, 8'h77, mrga_pkg::DEFAULT_ADDR, both, 8'h0B, mrga_pkg::OP_NOP,
                      8'h00, 8'h00, 8'h00, 8'h00, 6'd5));
    // A plain acknowledgement is swallowed.
    send_msg(make_msg(1'b1, 8'h77, mrga_pkg::DEFAULT_ADDR, mrga_pkg::FLAG_ACK, 8'h0C,
                      mrga_pkg::OP_GET_PORT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd9));
    send_msg(make_msg(1'b0, 8'h78, mrga_pkg::DEFAULT_ADDR, 8'hFF, 8'h0D, mrga_pkg::OP_SET_PORT,
                      8'h00, 8'hFF, 8'h00, 8'hFF, 6'd9));
    send_msg(make_msg(1'b0, 8'h81, 8'h22, 8'h15, 8'h0E, mrga_pkg::OP_SET_ADDR,
                      8'h01, 8'h02, 8'h03, 8'h04, 6'd12));
    send_msg(make_msg(1'b1, 8'h82, 8'h00, mrga_pkg::FLAG_ACK, 8'h0F, mrga_pkg::OP_NOP,
                      8'h09, 8'h08, 8'h07, 8'h06, 6'd32));
    send_msg(make_msg(1'b1, mrga_pkg::SERIAL_ADDR, mrga_pkg::SERIAL_ADDR, 8'h01, 8'h10,
                      mrga_pkg::OP_GET_PORT, 8'h00, 8'hFF, 8'h00, 8'hFF, 6'd9));
    send_msg(make_msg(1'b0, 8'h00, mrga_pkg::SERIAL_ADDR, 8'h02, 8'h11, mrga_pkg::OP_GET_ADDR,
                      8'h00, 8'h00, 8'h00, 8'h00, 6'd5));
    // Address 0xFF makes every message to 0xFF a local one.
    send_msg(make_msg(1'b0, 8'h90, mrga_pkg::DEFAULT_ADDR, 8'h00, 8'h12, mrga_pkg::OP_SET_ADDR,
                      mrga_pkg::SERIAL_ADDR, 8'h00, 8'h00, 8'h00, 6'd5));
    send_msg(make_msg(1'b1, 8'h33, mrga_pkg::SERIAL_ADDR, 8'h00, 8'h13, mrga_pkg::OP_GET_ADDR,
                      8'h00, 8'h00, 8'h00, 8'h00, 6'd5));
    send_msg(make_msg(1'b0, 8'h12, mrga_pkg::SERIAL_ADDR, 8'h00, 8'h14, mrga_pkg::OP_SET_ADDR,
                      8'h00, 8'h00, 8'h00, 8'h00, 6'd5));
    send_msg(make_msg(1'b1, 8'hFF, 8'h00, 8'h3F, 8'hFF, mrga_pkg::OP_GET_ADDR,
                      8'h00, 8'h00, 8'h00, 8'h00, 6'd5));
    send_msg(make_msg(1'b0, 8'h13, 8'h00, 8'h00, 8'h15, mrga_pkg::OP_SET_ADDR,
                      mrga_pkg::DEFAULT_ADDR, 8'h00, 8'h00, 8'h00, 6'd5));
    // Arguments are used even when the length says they are absent.
    send_msg(make_msg(1'b1, 8'h14, mrga_pkg::DEFAULT_ADDR, 8'h00, 8'h16, mrga_pkg::OP_SET_PORT,
                      8'h0F, 8'h3C, 8'hF0, 8'hC3, 6'd5));
    send_msg(make_msg(1'b0, 8'h15, mrga_pkg::DEFAULT_ADDR, 8'h00, 8'h17, mrga_pkg::OP_GET_PORT,
                      8'h00, 8'hFF, 8'h00, 8'hFF, 6'd5));
  endtask

  // Reply side: ready comes and goes, with one long hold-off that backs the
  // block up into its input.
  initial begin
    int stretch;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      stretch = $urandom_range(1, 6);
      repeat (stretch) @(posedge clk);
      stretch = pick_gap();
      if (stretch > 0) begin
        out_ready <= 1'b0;
        repeat (stretch) @(posedge clk);
      end
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_ready <= 1'b0;
        repeat (120) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p == 3) begin
        write_mask(mrga_pkg::REG_PORT0_MASK, 8'($urandom));
        write_mask(mrga_pkg::REG_PORT1_MASK, 8'($urandom));
      end else begin
        write_mask(mrga_pkg::REG_PORT0_MASK, phase_keep0[p]);
        write_mask(mrga_pkg::REG_PORT1_MASK, phase_keep1[p]);
      end
      no_gaps = (p == 2 || p == 5);
      squeeze_req = (p == 3);
      repeat (phase_items[p]) send_msg(random_msg());
    end
    settle();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== message_router_gpio_agent.f =====
rtl/mrga_pkg.sv
rtl/mrga_regs.sv
rtl/mrga_exec.sv
rtl/message_router_gpio_agent.sv
verif/mrga_reply_checker.sv
verif/message_router_gpio_agent_test.sv
